>>> src/assert_macros.svh
// assertion helpers shared by the rtl
// ASSERT_HOLDS checks a property every clock outside reset
// ASSERT_NEVER checks that a condition never shows outside reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

>>> src/crc8fc_pkg.sv
`default_nettype none

package crc8fc_pkg;

    localparam logic [7:0] CRC_POLY     = 8'hB7;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] FRAME_HEADER = 8'hA5;
    localparam logic [7:0] LEN_MIN      = 8'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_CHECK  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADHDR = 2'd1,
        ST_BADCRC = 2'd2,
        ST_BADLEN = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] crc;
        status_t    status;
    } result_t;

    // one byte through the crc, msb first, unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crc8fc_result_reg.sv
`default_nettype none

module crc8fc_result_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc8fc_pkg::result_t load_data,
    output logic                space,
    output logic                m_tvalid,
    input  logic                m_tready,
    output crc8fc_pkg::result_t m_data
);
    import crc8fc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // slot frees up in the same cycle the sink takes the item
    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

>>> src/crc8_frame_checker.sv
`default_nettype none
`include "assert_macros.svh"

// channel   | side   | tdata fields (lsb first)                         | tuser/tlast
// ----------+--------+--------------------------------------------------+------------
// s_t*      | input  | data_byte[7:0]                                   | none
// m_t*      | output | frame_status[1:0], computed_crc[9:2], zero[15:10]| none
//
// one byte is taken every cycle while s_tready is high; the parser and the
// unrolled crc-8 update sit between the input byte register and the result
// register; a result shows on m_t* once its closing byte has passed both
// reset clears the parser to expect a header with the crc at its initial value
// a stalled result only holds the input side back when the byte waiting in
// the input register would itself produce a result

module crc8_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // frame_status[1:0], computed_crc[9:2], zero pad
);
    import crc8fc_pkg::*;

    // input byte register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // parser state
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    // per-byte decisions
    logic       emit;
    result_t    result;
    logic [7:0] crc_upd;
    logic [7:0] left_dec;
    logic       out_space;
    logic       stage_fire;
    logic       in_accept;

    result_t    m_data;

    assign crc_upd  = crc8_byte(crc_reg, in_byte_reg);
    assign left_dec = left_reg - 8'd1;

    // the byte in the register moves on unless its result has nowhere to go
    assign stage_fire = in_valid_reg && (!emit || out_space);
    assign s_tready   = !in_valid_reg || stage_fire;
    assign in_accept  = s_tvalid && s_tready;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (in_byte_reg == FRAME_HEADER)
                    phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                if (in_byte_reg < LEN_MIN)
                    phase_next = PH_HEADER;
                else if (in_byte_reg == LEN_MIN)
                    phase_next = PH_CHECK;     // no body, check byte comes next
                else
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (left_dec == 8'd0)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // result, crc and counter
    always_comb
    begin
        emit          = 1'b0;
        result.status = ST_OK;
        result.crc    = 8'd0;
        crc_next      = crc_reg;
        left_next     = left_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                crc_next = CRC_INIT;
                if (in_byte_reg != FRAME_HEADER)
                begin
                    // bad header reports a zero crc
                    emit          = 1'b1;
                    result.status = ST_BADHDR;
                    result.crc    = 8'd0;
                end
            end
            PH_LENGTH:
            begin
                if (in_byte_reg < LEN_MIN)
                begin
                    // nothing covered, crc stays at its initial value
                    emit          = 1'b1;
                    result.status = ST_BADLEN;
                    result.crc    = CRC_INIT;
                    crc_next      = CRC_INIT;
                    left_next     = 8'd0;
                end
                else
                begin
                    crc_next  = crc_upd;
                    left_next = in_byte_reg - LEN_MIN;
                end
            end
            PH_BODY:
            begin
                crc_next  = crc_upd;
                left_next = left_dec;
            end
            PH_CHECK:
            begin
                emit          = 1'b1;
                result.status = (in_byte_reg == crc_reg) ? ST_OK : ST_BADCRC;
                result.crc    = crc_reg;
                crc_next      = CRC_INIT;
                left_next     = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        priority if (in_accept)
            in_valid_next = 1'b1;
        else if (stage_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HEADER;
            left_reg     <= 8'd0;
            crc_reg      <= CRC_INIT;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (stage_fire)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                crc_reg   <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= s_tdata;
    end

    crc8fc_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_fire && emit),
        .load_data (result),
        .space     (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (m_data)
    );

    assign m_tdata = {6'd0, m_data.crc, m_data.status};

    // body phase is only entered with bytes still to come
    `ASSERT_NEVER(a_body_has_bytes, clk, rst_n, (phase_reg == PH_BODY) && (left_reg == 8'd0), "body phase with no bytes left")
    // waiting for a header always means a fresh crc
    `ASSERT_HOLDS(a_header_crc_init, clk, rst_n, (phase_reg == PH_HEADER) |-> (crc_reg == CRC_INIT), "crc not reset while expecting header")
    // header errors carry a zero crc, length errors the initial value
    `ASSERT_HOLDS(a_badhdr_crc, clk, rst_n, (m_tvalid && (m_data.status == ST_BADHDR)) |-> (m_data.crc == 8'd0), "bad header result with nonzero crc")
    `ASSERT_HOLDS(a_badlen_crc, clk, rst_n, (m_tvalid && (m_data.status == ST_BADLEN)) |-> (m_data.crc == CRC_INIT), "length error result with wrong crc")

endmodule

`default_nettype wire
